>>> hw/rtl/lpl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpl_pkg
// Shared types and constants of the look-ahead peak limiter: payload beats,
// register indexes, controller states, and the command/status bundles.
// ----------------------------------------------------------------------------
package lpl_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int DRIVE_W     = 16;
    localparam int CEIL_W      = 24;
    localparam int GAIN_W      = 24;
    localparam int GAIN_FRAC   = 23;
    localparam int DRIVE_FRAC  = 12;
    localparam int X_W         = SAMPLE_BITS + 4;  // driven sample width
    localparam int CFG_W       = 24;
    localparam int DIV_STEPS   = 23;
    localparam int DIV_CNT_W   = 5;

    localparam logic [GAIN_W-1:0]  GAIN_UNITY  = 24'd8388608;
    localparam logic [DRIVE_W-1:0] DRIVE_RESET = 16'd4096;
    localparam logic [CEIL_W-1:0]  CEIL_RESET  = 24'd7476355;

    typedef enum logic {
        CFG_DRIVE_GAIN    = 1'b0,
        CFG_CEILING_LEVEL = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
    } in_beat_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
        logic        [GAIN_W-1:0]      left_gain;
        logic        [GAIN_W-1:0]      right_gain;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_DLY,
        ST_BACK_RD,
        ST_BACK_CMP,
        ST_FRONT_RD,
        ST_FRONT_CMP,
        ST_PUSH,
        ST_PEAK_RD,
        ST_PEAK_LD,
        ST_DIV_CHK,
        ST_DIV,
        ST_DIV_END,
        ST_OUT_MUL,
        ST_OUT_SAT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load_in;
        logic ch;
        logic mul_x;
        logic dly_wr;
        logic back_rd;
        logic drop_back;
        logic front_rd;
        logic drop_front;
        logic push;
        logic peak_rd;
        logic peak_ld;
        logic gain_unity;
        logic div_init;
        logic div_step;
        logic div_end;
        logic out_mul;
        logic out_sat;
        logic advance;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic back_gt;
        logic front_old;
        logic peak_trivial;
        logic out_busy;
    } sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/lpl_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpl_ctrl
// Sequencer: walks each channel through drive, delay, queue pops, push,
// peak read, divide and output scaling, then hands the beat out.
// ----------------------------------------------------------------------------
module lpl_ctrl import lpl_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t               state_reg, state_next;
    logic                 ch_reg, ch_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ch_reg    <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ch_next    = ch_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.ch     = ch_reg;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    ch_next     = 1'b0;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_x  = 1'b1;
                state_next = ST_DLY;
            end
            ST_DLY: begin
                cmd.dly_wr = 1'b1;
                state_next = ST_BACK_RD;
            end
            ST_BACK_RD: begin
                if (sts.count_zero) begin
                    state_next = ST_FRONT_RD;
                end else begin
                    cmd.back_rd = 1'b1;
                    state_next  = ST_BACK_CMP;
                end
            end
            ST_BACK_CMP: begin
                if (sts.back_gt) begin
                    state_next = ST_FRONT_RD;
                end else begin
                    cmd.drop_back = 1'b1;
                    state_next    = ST_BACK_RD;
                end
            end
            ST_FRONT_RD: begin
                if (sts.count_zero) begin
                    state_next = ST_PUSH;
                end else begin
                    cmd.front_rd = 1'b1;
                    state_next   = ST_FRONT_CMP;
                end
            end
            ST_FRONT_CMP: begin
                if (sts.front_old) begin
                    cmd.drop_front = 1'b1;
                    state_next     = ST_FRONT_RD;
                end else begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                cmd.push   = 1'b1;
                state_next = ST_PEAK_RD;
            end
            ST_PEAK_RD: begin
                cmd.peak_rd = 1'b1;
                state_next  = ST_PEAK_LD;
            end
            ST_PEAK_LD: begin
                cmd.peak_ld = 1'b1;
                state_next  = ST_DIV_CHK;
            end
            ST_DIV_CHK: begin
                if (sts.peak_trivial) begin
                    cmd.gain_unity = 1'b1;
                    state_next     = ST_OUT_MUL;
                end else begin
                    cmd.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_DIV_END;
                end
            end
            ST_DIV_END: begin
                cmd.div_end = 1'b1;
                state_next  = ST_OUT_MUL;
            end
            ST_OUT_MUL: begin
                cmd.out_mul = 1'b1;
                state_next  = ST_OUT_SAT;
            end
            ST_OUT_SAT: begin
                cmd.out_sat = 1'b1;
                if (ch_reg) begin
                    state_next = ST_FINISH;
                end else begin
                    ch_next    = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_FINISH: begin
                if (!sts.out_busy) begin
                    cmd.advance = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> hw/rtl/lpl_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpl_datapath
// Registers, delay lines, peak queues, restoring divider and output stage.
// ----------------------------------------------------------------------------
module lpl_datapath import lpl_pkg::*; #(
    parameter int LOOKAHEAD_SAMPLES = 256
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire in_beat_t          s_data,
    input  wire logic              cfg_we,
    input  wire logic [0:0]        cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_wdata,
    input  wire logic              m_ready,
    output logic                   m_valid,
    output out_beat_t              m_data,
    input  wire cmd_t              cmd,
    output sts_t                   sts
);

    localparam int WINDOW = LOOKAHEAD_SAMPLES + 1;
    localparam int PTR_W  = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int IDX_W  = $clog2(WINDOW) + 1;
    localparam int POS_W  = (LOOKAHEAD_SAMPLES > 1) ? $clog2(LOOKAHEAD_SAMPLES) : 1;
    localparam int Q_W    = IDX_W + X_W;
    localparam int PROD_W = X_W + GAIN_W + 1;
    localparam int Y_W    = PROD_W - GAIN_FRAC;
    localparam int N_W    = CEIL_W + SAMPLE_BITS - 1;

    localparam logic [CNT_W-1:0] WIN_CNT = CNT_W'(WINDOW);
    localparam logic [PTR_W:0]   WIN_SUM = (PTR_W + 1)'(WINDOW);
    localparam logic [IDX_W-1:0] WIN_IDX = IDX_W'(WINDOW);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(LOOKAHEAD_SAMPLES - 1);
    localparam logic signed [Y_W-1:0] Y_MAX = Y_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [Y_W-1:0] Y_MIN = -Y_MAX - Y_W'(1);

    // configuration
    logic [DRIVE_W-1:0] drive_reg;
    logic [CEIL_W-1:0]  ceil_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_reg <= DRIVE_RESET;
            ceil_reg  <= CEIL_RESET;
        end else if (cfg_we) begin
            if (cfg_index == CFG_DRIVE_GAIN) begin
                drive_reg <= cfg_wdata[DRIVE_W-1:0];
            end else begin
                ceil_reg <= cfg_wdata[CEIL_W-1:0];
            end
        end
    end

    // drive stage
    in_beat_t                      in_reg;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic signed [DRIVE_W:0]       drive_s;
    logic signed [SAMPLE_BITS+DRIVE_W:0] drv_prod;
    logic signed [X_W-1:0]         x_next, x_reg;
    logic        [X_W-1:0]         mag_next, mag_reg;

    assign sample   = cmd.ch ? in_reg.right_sample : in_reg.left_sample;
    assign drive_s  = {1'b0, drive_reg};
    assign drv_prod = sample * drive_s;
    assign x_next   = drv_prod[X_W+DRIVE_FRAC-1:DRIVE_FRAC];
    assign mag_next = x_next[X_W-1] ? X_W'(-x_next) : X_W'(x_next);

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= s_data;
        end
        if (cmd.mul_x) begin
            x_reg   <= x_next;
            mag_reg <= mag_next;
        end
    end

    // delay lines; the pointer fills them in order, so one wrap flag
    // stands in for the zero reset of every entry
    logic signed [X_W-1:0] dly_mem0 [LOOKAHEAD_SAMPLES];
    logic signed [X_W-1:0] dly_mem1 [LOOKAHEAD_SAMPLES];
    logic signed [X_W-1:0] dly_rd0_reg, dly_rd1_reg, delayed_reg;
    logic [POS_W-1:0]      pos_reg;
    logic                  wrapped_reg;
    logic [IDX_W-1:0]      idx_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mul_x) begin
            dly_rd0_reg <= dly_mem0[pos_reg];
            dly_rd1_reg <= dly_mem1[pos_reg];
        end
        if (cmd.dly_wr) begin
            if (cmd.ch) begin
                dly_mem1[pos_reg] <= x_reg;
            end else begin
                dly_mem0[pos_reg] <= x_reg;
            end
            if (wrapped_reg) begin
                delayed_reg <= cmd.ch ? dly_rd1_reg : dly_rd0_reg;
            end else begin
                delayed_reg <= '0;
            end
        end
    end

    // peak queues: {sample index, magnitude}
    logic [Q_W-1:0]   q_mem0 [WINDOW];
    logic [Q_W-1:0]   q_mem1 [WINDOW];
    logic [Q_W-1:0]   q_rd0_reg, q_rd1_reg, q_rd;
    logic [PTR_W-1:0] head_reg  [2];
    logic [CNT_W-1:0] count_reg [2];
    logic [PTR_W-1:0] head, back, slot, head_inc, rd_addr;
    logic [CNT_W-1:0] count;
    logic [PTR_W:0]   back_sum, slot_sum;
    logic [X_W-1:0]   rd_mag;
    logic [IDX_W-1:0] rd_idx;

    assign head     = head_reg[cmd.ch];
    assign count    = count_reg[cmd.ch];
    assign slot_sum = (PTR_W + 1)'(head) + (PTR_W + 1)'(count);
    assign back_sum = slot_sum - 1'b1;
    assign back     = (back_sum >= WIN_SUM) ? PTR_W'(back_sum - WIN_SUM) : PTR_W'(back_sum);
    assign slot     = (slot_sum >= WIN_SUM) ? PTR_W'(slot_sum - WIN_SUM) : PTR_W'(slot_sum);
    assign head_inc = ((PTR_W + 1)'(head) + 1'b1 == WIN_SUM) ? '0 : head + 1'b1;
    assign rd_addr  = cmd.back_rd ? back : head;
    assign q_rd     = cmd.ch ? q_rd1_reg : q_rd0_reg;
    assign rd_mag   = q_rd[X_W-1:0];
    assign rd_idx   = q_rd[Q_W-1:X_W];

    always_ff @(posedge aclk) begin
        if (cmd.back_rd || cmd.front_rd || cmd.peak_rd) begin
            q_rd0_reg <= q_mem0[rd_addr];
            q_rd1_reg <= q_mem1[rd_addr];
        end
        if (cmd.push) begin
            if (cmd.ch) begin
                q_mem1[slot] <= {idx_reg, mag_reg};
            end else begin
                q_mem0[slot] <= {idx_reg, mag_reg};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg[0]  <= '0;
            head_reg[1]  <= '0;
            count_reg[0] <= '0;
            count_reg[1] <= '0;
        end else if (cmd.drop_back) begin
            count_reg[cmd.ch] <= count - 1'b1;
        end else if (cmd.drop_front) begin
            head_reg[cmd.ch]  <= head_inc;
            count_reg[cmd.ch] <= count - 1'b1;
        end else if (cmd.push) begin
            count_reg[cmd.ch] <= count + 1'b1;
        end
    end

    // gain: saturation test, then restoring divide of ceiling * 2^(n-1) by peak
    logic [X_W-1:0]           peak_reg, rem_reg;
    logic [N_W-1:0]           num;
    logic [SAMPLE_BITS-1:0]   num_hi;
    logic [GAIN_FRAC-1:0]     nsh_reg, quo_reg;
    logic [X_W:0]             trial;
    logic                     trial_ge;
    logic [GAIN_W-1:0]        gain_reg;

    assign num      = {ceil_reg, {(SAMPLE_BITS - 1){1'b0}}};
    assign num_hi   = num[N_W-1:GAIN_FRAC];
    assign trial    = {rem_reg, nsh_reg[GAIN_FRAC-1]};
    assign trial_ge = trial >= {1'b0, peak_reg};

    always_ff @(posedge aclk) begin
        if (cmd.peak_ld) begin
            peak_reg <= rd_mag;
        end
        if (cmd.gain_unity) begin
            gain_reg <= GAIN_UNITY;
        end else if (cmd.div_end) begin
            gain_reg <= {1'b0, quo_reg};
        end
        if (cmd.div_init) begin
            rem_reg <= X_W'(num_hi);
            nsh_reg <= num[GAIN_FRAC-1:0];
            quo_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= trial_ge ? X_W'(trial - {1'b0, peak_reg}) : X_W'(trial);
            nsh_reg <= {nsh_reg[GAIN_FRAC-2:0], 1'b0};
            quo_reg <= {quo_reg[GAIN_FRAC-2:0], trial_ge};
        end
    end

    // output scaling and saturation
    logic signed [GAIN_W:0]         gain_s;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [Y_W-1:0]          y;
    logic signed [SAMPLE_BITS-1:0]  y_sat;
    logic signed [SAMPLE_BITS-1:0]  res_out_reg  [2];
    logic        [GAIN_W-1:0]       res_gain_reg [2];
    out_beat_t                      out_reg;
    logic                           out_valid_reg;

    assign gain_s = {1'b0, gain_reg};
    assign y      = prod_reg[PROD_W-1:GAIN_FRAC];
    always_comb begin
        if (y > Y_MAX) begin
            y_sat = SAMPLE_BITS'(Y_MAX);
        end else if (y < Y_MIN) begin
            y_sat = SAMPLE_BITS'(Y_MIN);
        end else begin
            y_sat = y[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_mul) begin
            prod_reg <= delayed_reg * gain_s;
        end
        if (cmd.out_sat) begin
            res_out_reg[cmd.ch]  <= y_sat;
            res_gain_reg[cmd.ch] <= gain_reg;
        end
        if (cmd.advance) begin
            out_reg.left_out   <= res_out_reg[0];
            out_reg.right_out  <= res_out_reg[1];
            out_reg.left_gain  <= res_gain_reg[0];
            out_reg.right_gain <= res_gain_reg[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            wrapped_reg   <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.advance) begin
                idx_reg       <= idx_reg + 1'b1;
                out_valid_reg <= 1'b1;
                if (pos_reg == POS_LAST) begin
                    pos_reg     <= '0;
                    wrapped_reg <= 1'b1;
                end else begin
                    pos_reg <= pos_reg + 1'b1;
                end
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assign sts.count_zero   = (count == '0);
    assign sts.back_gt      = rd_mag > mag_reg;
    assign sts.front_old    = (idx_reg - rd_idx) >= WIN_IDX;
    assign sts.peak_trivial = (peak_reg == '0) || ({4'b0, num_hi} >= peak_reg);
    assign sts.out_busy     = out_valid_reg && !m_ready;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg[0] <= WIN_CNT) && (count_reg[1] <= WIN_CNT))
        else $error("peak queue count beyond window");
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> (count < WIN_CNT))
        else $error("push into a full peak queue");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.advance |-> (!out_valid_reg || m_ready))
        else $error("result register overwritten while held");
    a_gain_unity: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_reg.left_gain <= GAIN_UNITY
                           && out_reg.right_gain <= GAIN_UNITY))
        else $error("gain above unity");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/lookahead_peak_limiter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lookahead_peak_limiter_core
// Look-ahead brickwall limiter for stereo Q1.23 sample pairs.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data take one stereo pair per beat. m_valid/m_ready/
//   m_data return one beat per input beat: both channels delayed by
//   LOOKAHEAD_SAMPLES, scaled by min(1, ceiling/peak) over a window of
//   LOOKAHEAD_SAMPLES+1 driven samples, saturated, plus the gains applied.
//   cfg_we/cfg_index/cfg_wdata write drive_gain (0) or ceiling_level (1);
//   write only while the block is idle.
// Timing:
//   One pair at a time. Each channel runs through a shared sequence: drive,
//   delay and queue bookkeeping (shorter for each queue scan that finds
//   the queue empty), a read and a compare for each queue entry dropped,
//   restoring divide and gain load (skipped when the gain is unity), and
//   output scaling. m_valid rises once both channels are done; queue
//   drops average under one per sample.
// Reset:
//   aresetn (synchronous, low) restores register defaults, empties the peak
//   queues and marks the delay lines as holding zero. No clearing pass.
// Stall:
//   A finished beat waits in the output register while the next pair is
//   taken in; the block holds in its last step until that register frees.
// ----------------------------------------------------------------------------
module lookahead_peak_limiter_core import lpl_pkg::*; #(
    parameter int LOOKAHEAD_SAMPLES = 256
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire in_beat_t         s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output out_beat_t             m_data,
    input  wire logic             cfg_we,
    input  wire logic [0:0]       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_wdata
);

    // command and status between sequencer and datapath
    cmd_t cmd;
    sts_t sts;

    lpl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lpl_datapath #(
        .LOOKAHEAD_SAMPLES (LOOKAHEAD_SAMPLES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
`default_nettype wire
